@@ hw/rtl/kf2_pkg.sv @@
`default_nettype none
package kf2_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;

  typedef struct packed {
    logic               first;
    logic signed [31:0] measurement;
  } in_t;

  typedef struct packed {
    logic signed [31:0] estimate_0;
    logic signed [31:0] estimate_1;
    logic [30:0]        bound_0;
    logic [30:0]        bound_1;
  } out_t;

  // register indexes on the configuration port
  localparam logic [2:0] CFG_ROW0   = 3'd0;
  localparam logic [2:0] CFG_ROW1   = 3'd1;
  localparam logic [2:0] CFG_UGAIN  = 3'd2;
  localparam logic [2:0] CFG_HROW   = 3'd3;
  localparam logic [2:0] CFG_NOISE  = 3'd4;
  localparam logic [2:0] CFG_PDIAG  = 3'd5;
  localparam logic [2:0] CFG_POFF   = 3'd6;
  localparam int         CFG_COUNT  = 7;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_BND = 3'd4,
    OP_JNF = 3'd5,
    OP_OUT = 3'd6,
    OP_END = 3'd7
  } op_t;

  // operand space: 0..15 register file, 16..31 constants
  localparam logic [4:0] R_X0 = 5'd0;
  localparam logic [4:0] R_X1 = 5'd1;
  localparam logic [4:0] R_P0 = 5'd2;
  localparam logic [4:0] R_P1 = 5'd3;
  localparam logic [4:0] R_P2 = 5'd4;
  localparam logic [4:0] R_P3 = 5'd5;
  localparam logic [4:0] R_T0 = 5'd6;
  localparam logic [4:0] R_T1 = 5'd7;
  localparam logic [4:0] R_T2 = 5'd8;
  localparam logic [4:0] R_T3 = 5'd9;
  localparam logic [4:0] R_T4 = 5'd10;
  localparam logic [4:0] R_T5 = 5'd11;
  localparam logic [4:0] R_T6 = 5'd12;
  localparam logic [4:0] R_T7 = 5'd13;
  localparam logic [4:0] R_T8 = 5'd14;
  localparam logic [4:0] R_Y  = 5'd15;
  localparam logic [4:0] S_F00  = 5'd16;
  localparam logic [4:0] S_F01  = 5'd17;
  localparam logic [4:0] S_F10  = 5'd18;
  localparam logic [4:0] S_F11  = 5'd19;
  localparam logic [4:0] S_U0   = 5'd20;
  localparam logic [4:0] S_U1   = 5'd21;
  localparam logic [4:0] S_H0   = 5'd22;
  localparam logic [4:0] S_H1   = 5'd23;
  localparam logic [4:0] S_R    = 5'd24;
  localparam logic [4:0] S_Q    = 5'd25;
  localparam logic [4:0] S_SP00 = 5'd26;
  localparam logic [4:0] S_SP11 = 5'd27;
  localparam logic [4:0] S_SP01 = 5'd28;
  localparam logic [4:0] S_SP10 = 5'd29;
  localparam logic [4:0] S_ONE  = 5'd30;
  localparam logic [4:0] S_ZERO = 5'd31;

  localparam int PROG_LEN = 92;
  localparam int PC_BITS  = $clog2(PROG_LEN);

  typedef struct packed {
    op_t                op;
    logic [3:0]         dst;
    logic [4:0]         srca;
    logic [4:0]         srcb;
    logic [PC_BITS-1:0] tgt;
  } uword_t;

  localparam logic [PC_BITS-1:0] L_PRIOR = PC_BITS'(7);

  function automatic uword_t mk(op_t op, logic [4:0] d, logic [4:0] a, logic [4:0] b);
    uword_t w;
    w.op   = op;
    w.dst  = d[3:0];
    w.srca = a;
    w.srcb = b;
    w.tgt  = L_PRIOR;
    return w;
  endfunction

  // filter program; bound writes pick the bound register by dst bit 0
  function automatic uword_t ucode(logic [PC_BITS-1:0] pc);
    uword_t w;
    unique case (pc)
      // new run: clear estimate, load starting covariance
      7'd0:  w = mk(OP_JNF, R_X0, S_ZERO, S_ZERO);
      7'd1:  w = mk(OP_ADD, R_X0, S_ZERO, S_ZERO);
      7'd2:  w = mk(OP_ADD, R_X1, S_ZERO, S_ZERO);
      7'd3:  w = mk(OP_ADD, R_P0, S_SP00, S_ZERO);
      7'd4:  w = mk(OP_ADD, R_P3, S_SP11, S_ZERO);
      7'd5:  w = mk(OP_ADD, R_P1, S_SP01, S_ZERO);
      7'd6:  w = mk(OP_ADD, R_P2, S_SP10, S_ZERO);
      // sigma bounds of the prior
      7'd7:  w = mk(OP_BND, R_X0, R_P0, S_ZERO);
      7'd8:  w = mk(OP_BND, R_X1, R_P3, S_ZERO);
      // P*H'
      7'd9:  w = mk(OP_MUL, R_T0, R_P0, S_H0);
      7'd10: w = mk(OP_MUL, R_T1, R_P1, S_H1);
      7'd11: w = mk(OP_ADD, R_T0, R_T0, R_T1);
      7'd12: w = mk(OP_MUL, R_T1, R_P2, S_H0);
      7'd13: w = mk(OP_MUL, R_T2, R_P3, S_H1);
      7'd14: w = mk(OP_ADD, R_T1, R_T1, R_T2);
      // innovation variance and gain
      7'd15: w = mk(OP_MUL, R_T2, S_H0, R_T0);
      7'd16: w = mk(OP_MUL, R_T3, S_H1, R_T1);
      7'd17: w = mk(OP_ADD, R_T2, R_T2, R_T3);
      7'd18: w = mk(OP_ADD, R_T2, R_T2, S_R);
      7'd19: w = mk(OP_DIV, R_T3, R_T0, R_T2);
      7'd20: w = mk(OP_DIV, R_T4, R_T1, R_T2);
      // I - K*H
      7'd21: w = mk(OP_MUL, R_T0, R_T3, S_H0);
      7'd22: w = mk(OP_SUB, R_T0, S_ONE, R_T0);
      7'd23: w = mk(OP_MUL, R_T1, R_T3, S_H1);
      7'd24: w = mk(OP_SUB, R_T1, S_ZERO, R_T1);
      7'd25: w = mk(OP_MUL, R_T2, R_T4, S_H0);
      7'd26: w = mk(OP_SUB, R_T2, S_ZERO, R_T2);
      7'd27: w = mk(OP_MUL, R_T5, R_T4, S_H1);
      7'd28: w = mk(OP_SUB, R_T5, S_ONE, R_T5);
      // updated covariance N
      7'd29: w = mk(OP_MUL, R_T6, R_T0, R_P0);
      7'd30: w = mk(OP_MUL, R_T7, R_T1, R_P2);
      7'd31: w = mk(OP_ADD, R_T6, R_T6, R_T7);
      7'd32: w = mk(OP_MUL, R_T7, R_T0, R_P1);
      7'd33: w = mk(OP_MUL, R_T8, R_T1, R_P3);
      7'd34: w = mk(OP_ADD, R_T7, R_T7, R_T8);
      7'd35: w = mk(OP_MUL, R_T0, R_T2, R_P0);
      7'd36: w = mk(OP_MUL, R_T1, R_T5, R_P2);
      7'd37: w = mk(OP_ADD, R_T0, R_T0, R_T1);
      7'd38: w = mk(OP_MUL, R_T1, R_T2, R_P1);
      7'd39: w = mk(OP_MUL, R_T8, R_T5, R_P3);
      7'd40: w = mk(OP_ADD, R_T1, R_T1, R_T8);
      // estimate update
      7'd41: w = mk(OP_MUL, R_T2, S_H0, R_X0);
      7'd42: w = mk(OP_MUL, R_T5, S_H1, R_X1);
      7'd43: w = mk(OP_ADD, R_T2, R_T2, R_T5);
      7'd44: w = mk(OP_SUB, R_T2, R_Y, R_T2);
      7'd45: w = mk(OP_MUL, R_T5, R_T3, R_T2);
      7'd46: w = mk(OP_ADD, R_X0, R_X0, R_T5);
      7'd47: w = mk(OP_MUL, R_T5, R_T4, R_T2);
      7'd48: w = mk(OP_ADD, R_X1, R_X1, R_T5);
      7'd49: w = mk(OP_OUT, R_X0, R_X0, R_X1);
      // x = Phi*x
      7'd50: w = mk(OP_MUL, R_T2, S_F00, R_X0);
      7'd51: w = mk(OP_MUL, R_T3, S_F01, R_X1);
      7'd52: w = mk(OP_ADD, R_T2, R_T2, R_T3);
      7'd53: w = mk(OP_MUL, R_T3, S_F10, R_X0);
      7'd54: w = mk(OP_MUL, R_T4, S_F11, R_X1);
      7'd55: w = mk(OP_ADD, R_X1, R_T3, R_T4);
      7'd56: w = mk(OP_ADD, R_X0, R_T2, S_ZERO);
      // M = Phi*N
      7'd57: w = mk(OP_MUL, R_T2, S_F00, R_T6);
      7'd58: w = mk(OP_MUL, R_T3, S_F01, R_T0);
      7'd59: w = mk(OP_ADD, R_T2, R_T2, R_T3);
      7'd60: w = mk(OP_MUL, R_T3, S_F00, R_T7);
      7'd61: w = mk(OP_MUL, R_T4, S_F01, R_T1);
      7'd62: w = mk(OP_ADD, R_T3, R_T3, R_T4);
      7'd63: w = mk(OP_MUL, R_T4, S_F10, R_T6);
      7'd64: w = mk(OP_MUL, R_T5, S_F11, R_T0);
      7'd65: w = mk(OP_ADD, R_T4, R_T4, R_T5);
      7'd66: w = mk(OP_MUL, R_T5, S_F10, R_T7);
      7'd67: w = mk(OP_MUL, R_T8, S_F11, R_T1);
      7'd68: w = mk(OP_ADD, R_T5, R_T5, R_T8);
      // U*Q
      7'd69: w = mk(OP_MUL, R_T6, S_U0, S_Q);
      7'd70: w = mk(OP_MUL, R_T7, S_U1, S_Q);
      // P = M*Phi' + U*Q*U'
      7'd71: w = mk(OP_MUL, R_T0, R_T2, S_F00);
      7'd72: w = mk(OP_MUL, R_T1, R_T3, S_F01);
      7'd73: w = mk(OP_ADD, R_T0, R_T0, R_T1);
      7'd74: w = mk(OP_MUL, R_T1, R_T6, S_U0);
      7'd75: w = mk(OP_ADD, R_P0, R_T0, R_T1);
      7'd76: w = mk(OP_MUL, R_T0, R_T2, S_F10);
      7'd77: w = mk(OP_MUL, R_T1, R_T3, S_F11);
      7'd78: w = mk(OP_ADD, R_T0, R_T0, R_T1);
      7'd79: w = mk(OP_MUL, R_T1, R_T6, S_U1);
      7'd80: w = mk(OP_ADD, R_P1, R_T0, R_T1);
      7'd81: w = mk(OP_MUL, R_T0, R_T4, S_F00);
      7'd82: w = mk(OP_MUL, R_T1, R_T5, S_F01);
      7'd83: w = mk(OP_ADD, R_T0, R_T0, R_T1);
      7'd84: w = mk(OP_MUL, R_T1, R_T7, S_U0);
      7'd85: w = mk(OP_ADD, R_P2, R_T0, R_T1);
      7'd86: w = mk(OP_MUL, R_T0, R_T4, S_F10);
      7'd87: w = mk(OP_MUL, R_T1, R_T5, S_F11);
      7'd88: w = mk(OP_ADD, R_T0, R_T0, R_T1);
      7'd89: w = mk(OP_MUL, R_T1, R_T7, S_U1);
      7'd90: w = mk(OP_ADD, R_P3, R_T0, R_T1);
      default: w = mk(OP_END, R_X0, S_ZERO, S_ZERO);
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/kalman_filter_two_state.sv @@
// Two-state Kalman filter, scalar measurement, microcoded on one shared datapath.
// A transaction runs the whole microcode program, a longer part of it with a run start;
// the out step stalls until the result register is free (result_ready).
// Throughput: one transaction per program run; the next sample is taken when it ends.
// Reset (rst, synchronous) zeroes state, estimate, covariance and configuration.
`default_nettype none
module kalman_filter_two_state #(
  parameter int WORD_BITS     = kf2_pkg::WORD_BITS_DEF,
  parameter int FRACTION_BITS = kf2_pkg::FRAC_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         sample_valid,
  output logic              sample_ready,
  input  wire kf2_pkg::in_t sample,
  output logic              result_valid,
  input  wire logic         result_ready,
  output kf2_pkg::out_t     result,
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [63:0]  cfg_data
);
  import kf2_pkg::*;

  localparam int W   = WORD_BITS;
  localparam int F   = FRACTION_BITS;
  localparam int EW  = ((W > 32) ? W : 32) + 1;      // clamp width
  localparam int MW  = ((2 * W) > (W + F)) ? 2 * W : W + F;
  localparam int DN  = W + F;                          // dividend bits
  localparam int SQ  = DN + (DN % 2);                  // sqrt radicand bits
  localparam int SH  = SQ / 2;                         // root bits
  localparam int CW  = $clog2(DN + 1);
  localparam int BW  = SH + 33;

  localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] ONE_W = (F >= W - 1) ? WMAX : (W'(1) << F);
  localparam logic signed [EW-1:0] WMAX_E = EW'(signed'({1'b0, WMAX}));
  localparam logic signed [EW-1:0] WMIN_E = -WMAX_E - EW'(1);
  localparam logic signed [EW-1:0] I32MAX_E = EW'(33'sh0_7FFF_FFFF);
  localparam logic signed [EW-1:0] I32MIN_E = -I32MAX_E - EW'(1);
  localparam logic [BW-1:0] BMAX = BW'(31'h7FFF_FFFF);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_READ = 5'b00010,
    ST_EXEC = 5'b00100,
    ST_MULW = 5'b01000,
    ST_ITER = 5'b10000
  } state_t;

  // ---- helpers ---------------------------------------------------------
  // 32-bit signed half into the word, saturated
  function automatic logic [W-1:0] to_word(logic [31:0] h);
    logic signed [EW-1:0] e;
    e = {{(EW-32){h[31]}}, h};
    if (e > WMAX_E) return WMAX;
    if (e < WMIN_E) return WMIN;
    return e[W-1:0];
  endfunction

  // word into a 32-bit output field, saturated
  function automatic logic [31:0] to_out(logic [W-1:0] v);
    logic signed [EW-1:0] e;
    e = {{(EW-W){v[W-1]}}, v};
    if (e > I32MAX_E) return 32'h7FFF_FFFF;
    if (e < I32MIN_E) return 32'h8000_0000;
    return e[31:0];
  endfunction

  function automatic logic [W-1:0] mag(logic [W-1:0] a);
    return a[W-1] ? (~a + W'(1)) : a;
  endfunction

  // sign and magnitude to a saturated word
  function automatic logic [W-1:0] sat_mag(logic neg, logic [MW-1:0] m);
    logic [MW-1:0] lim;
    lim = MW'(1) << (W - 1);
    if (neg) begin
      if (m >= lim) return WMIN;
      return ~m[W-1:0] + W'(1);
    end
    if (m >= lim) return WMAX;
    return m[W-1:0];
  endfunction

  function automatic logic [W-1:0] sat_sum(logic [W-1:0] a, logic [W-1:0] b, logic sub);
    logic [W:0] s;
    s = sub ? ({a[W-1], a} - {b[W-1], b}) : ({a[W-1], a} + {b[W-1], b});
    if (s[W] != s[W-1]) return s[W] ? WMIN : WMAX;
    return s[W-1:0];
  endfunction

  // ---- configuration ---------------------------------------------------
  logic [63:0] cfg [CFG_COUNT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CFG_COUNT; i++) cfg[i] <= '0;
    end else if (cfg_we && (32'(cfg_index) < CFG_COUNT)) begin
      cfg[cfg_index] <= cfg_data;
    end
  end

  // constant operands: config halves in upper/lower order, then one and zero
  function automatic logic [W-1:0] const_src(logic [3:0] s);
    logic [63:0] r;
    if (s == S_ONE[3:0])  return ONE_W;
    if (s == S_ZERO[3:0]) return '0;
    r = cfg[s[3:1]];
    return s[0] ? to_word(r[31:0]) : to_word(r[63:32]);
  endfunction

  // ---- sequencer -------------------------------------------------------
  state_t             state;
  logic [PC_BITS-1:0] pc;
  uword_t             cw;          // control word being executed
  logic               first_r;

  // register file, registered operand reads
  logic [W-1:0] rf [16];
  logic [W-1:0] opa, opb;
  logic         wr_en;
  logic [3:0]   wr_addr;
  logic [W-1:0] wr_data;

  // multiply
  logic [2*W-1:0] prod;
  logic           prod_neg;

  // divide / square root
  logic [CW-1:0]  cnt;
  logic [SQ-1:0]  num;
  logic [W-1:0]   drem;
  logic [W-1:0]   dvs;
  logic [DN-1:0]  quo;
  logic           q_neg;
  logic [SH+1:0]  srem;
  logic [SH-1:0]  root;

  logic [W:0]     div_rs;
  logic           div_take;
  logic [SH+1:0]  sq_rs;
  logic [SH+1:0]  sq_trial;
  logic           sq_take;
  logic [BW-1:0]  b3;
  logic [30:0]    bound0, bound1;

  uword_t         fetch;
  logic           out_free;
  logic           accept;

  assign fetch    = ucode(pc);
  assign accept   = sample_valid && sample_ready;
  assign out_free = !result_valid || result_ready;
  assign sample_ready = (state == ST_IDLE);

  assign div_rs   = {drem, num[SQ-1]};
  assign div_take = (div_rs >= {1'b0, dvs});
  assign sq_rs    = {srem[SH-1:0], num[SQ-1:SQ-2]};
  assign sq_trial = {root, 2'b01};
  assign sq_take  = (sq_rs >= sq_trial);
  assign b3       = BW'({root, 1'b0}) + BW'(root);

  // single write port into the register file
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cw.dst;
    wr_data = '0;
    unique case (state)
      ST_IDLE: begin
        wr_en   = accept;
        wr_addr = R_Y[3:0];
        wr_data = to_word(sample.measurement);
      end
      ST_EXEC: begin
        if (cw.op == OP_ADD || cw.op == OP_SUB) begin
          wr_en   = 1'b1;
          wr_data = sat_sum(opa, opb, cw.op == OP_SUB);
        end else if (cw.op == OP_DIV && opb == '0) begin
          // zero divisor: saturate by the numerator's sign, zero for a zero numerator
          wr_en   = 1'b1;
          wr_data = (opa == '0) ? '0 : (opa[W-1] ? WMIN : WMAX);
        end
      end
      ST_MULW: begin
        wr_en   = 1'b1;
        wr_data = sat_mag(prod_neg, MW'(prod >> F));
      end
      ST_ITER: begin
        wr_en   = (cnt == '0) && (cw.op == OP_DIV);
        wr_data = sat_mag(q_neg, MW'(quo));
      end
      default: ;
    endcase
  end

  // estimate and covariance live here, so reset clears the whole file
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) rf[i] <= '0;
    end else if (wr_en) begin
      rf[wr_addr] <= wr_data;
    end
  end

  // output register: loaded by the out step, cleared when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == ST_EXEC && cw.op == OP_OUT && out_free) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      pc           <= '0;
      first_r      <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            first_r <= sample.first;
            pc      <= '0;
            state   <= ST_READ;
          end
        end
        ST_READ: begin
          state <= ST_EXEC;
        end
        ST_EXEC: begin
          unique case (cw.op)
            OP_ADD, OP_SUB: begin
              pc    <= pc + PC_BITS'(1);
              state <= ST_READ;
            end
            OP_MUL: state <= ST_MULW;
            OP_DIV: begin
              if (opb == '0) begin
                pc    <= pc + PC_BITS'(1);
                state <= ST_READ;
              end else begin
                state <= ST_ITER;
              end
            end
            OP_BND: begin
              // non-positive variance gives a zero bound at once
              if (opa[W-1] || opa == '0) begin
                pc    <= pc + PC_BITS'(1);
                state <= ST_READ;
              end else begin
                state <= ST_ITER;
              end
            end
            OP_JNF: begin
              pc    <= first_r ? pc + PC_BITS'(1) : cw.tgt;
              state <= ST_READ;
            end
            OP_OUT: begin
              if (out_free) begin
                pc           <= pc + PC_BITS'(1);
                state        <= ST_READ;
              end
            end
            OP_END: state <= ST_IDLE;
          endcase
        end
        ST_MULW: begin
          pc    <= pc + PC_BITS'(1);
          state <= ST_READ;
        end
        ST_ITER: begin
          if (cnt == '0) begin
            pc    <= pc + PC_BITS'(1);
            state <= ST_READ;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bound0 <= '0;
      bound1 <= '0;
    end else begin
      unique case (state)
        ST_READ: begin
          cw  <= fetch;
          opa <= fetch.srca[4] ? const_src(fetch.srca[3:0]) : rf[fetch.srca[3:0]];
          opb <= fetch.srcb[4] ? const_src(fetch.srcb[3:0]) : rf[fetch.srcb[3:0]];
        end
        ST_EXEC: begin
          unique case (cw.op)
            OP_MUL: begin
              prod     <= mag(opa) * mag(opb);
              prod_neg <= opa[W-1] ^ opb[W-1];
            end
            OP_DIV: begin
              num   <= {mag(opa), {(SQ-W){1'b0}}};
              drem  <= '0;
              dvs   <= mag(opb);
              quo   <= '0;
              q_neg <= opa[W-1] ^ opb[W-1];
              cnt   <= CW'(DN);
            end
            OP_BND: begin
              num  <= SQ'({opa, {F{1'b0}}});
              srem <= '0;
              root <= '0;
              cnt  <= CW'(SH);
              if (opa[W-1] || opa == '0) begin
                if (cw.dst[0]) bound1 <= '0;
                else           bound0 <= '0;
              end
            end
            OP_OUT: begin
              if (out_free) begin
                result.estimate_0 <= to_out(opa);
                result.estimate_1 <= to_out(opb);
                result.bound_0    <= bound0;
                result.bound_1    <= bound1;
              end
            end
            default: ;
          endcase
        end
        ST_ITER: begin
          if (cnt != '0) begin
            cnt <= cnt - CW'(1);
            if (cw.op == OP_DIV) begin
              // restoring divide, one quotient bit per cycle
              num  <= {num[SQ-2:0], 1'b0};
              quo  <= {quo[DN-2:0], div_take};
              drem <= div_take ? W'(div_rs - {1'b0, dvs}) : div_rs[W-1:0];
            end else begin
              // digit-by-digit square root, two radicand bits per cycle
              num  <= {num[SQ-3:0], 2'b00};
              srem <= sq_take ? (sq_rs - sq_trial) : sq_rs;
              root <= {root[SH-2:0], sq_take};
            end
          end else if (cw.op == OP_BND) begin
            if (cw.dst[0]) bound1 <= (b3 > BMAX) ? 31'h7FFF_FFFF : b3[30:0];
            else           bound0 <= (b3 > BMAX) ? 31'h7FFF_FFFF : b3[30:0];
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire
